### design/tdpf_pkg.sv
`default_nettype none
package tdpf_pkg;

	localparam int FILTER_CELLS = 32;
	localparam int VALUE_BITS   = 16;
	localparam int FIELD_BITS   = 16;
	localparam int IDX_BITS     = (FILTER_CELLS > 1) ? $clog2(FILTER_CELLS) : 1;
	localparam int CNT_BITS     = $clog2(FILTER_CELLS + 1);
	localparam int STEP_BITS    = $clog2(VALUE_BITS);

	typedef logic [VALUE_BITS-1:0] value_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] candidate_value;
		logic                  end_of_run;
	} cand_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] survivor_value;
		logic                  store_full;
	} surv_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_DIV,
		ST_PASS,
		ST_END
	} state_t;

endpackage
`default_nettype wire

### design/tdpf_ram.sv
`default_nettype none
// simple dual-port RAM, registered read
module tdpf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### design/tdpf_rem.sv
`default_nettype none
// bit-serial restoring remainder, one dividend bit per cycle
module tdpf_rem
	import tdpf_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   start,
	input  wire value_t dividend,
	input  wire value_t divisor,
	output logic        done,
	output logic        zero
);

	value_t                rem_q;
	value_t                dvd_q;
	value_t                dsr_q;
	logic [STEP_BITS-1:0]  step_q;
	logic                  busy_q;
	logic                  done_q;
	logic [VALUE_BITS:0]   trial;
	logic [VALUE_BITS:0]   dsr_ext;
	value_t                rem_next;

	always_comb begin
		trial    = {rem_q, dvd_q[VALUE_BITS-1]};
		dsr_ext  = {1'b0, dsr_q};
		if (trial >= dsr_ext) begin
			rem_next = VALUE_BITS'(trial - dsr_ext);
		end else begin
			rem_next = VALUE_BITS'(trial);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= STEP_BITS'(VALUE_BITS - 1);
		end else if (busy_q) begin
			if (step_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				step_q <= step_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			dvd_q <= dvd_q << 1;
		end
	end

	assign done = done_q;
	assign zero = (rem_q == '0);

endmodule
`default_nettype wire

### design/trial_division_prime_filter_chain.sv
`default_nettype none
// Trial-division prime filter. Each candidate transfer is checked against
// the stored divisors in order, oldest first; the first divisor that leaves
// a zero remainder drops it. A candidate that survives every divisor is sent
// out with store_full low and appended to the store, or with store_full high
// when all FILTER_CELLS slots are taken. Candidates below 2 are dropped.
// end_of_run empties the store once its own candidate is handled. One
// remainder unit is shared by all divisors and works one bit per cycle. Each
// divisor tried goes through read, load, VALUE_BITS remainder steps and
// done. cand_stall is low only in the idle state, where the transfer is
// taken. The result sits in an output register, so a stalled survivor
// transfer does not hold up the next candidate until that one itself
// survives.
module trial_division_prime_filter_chain
	import tdpf_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cand_valid,
	output logic       cand_stall,
	input  wire cand_t cand,
	output logic       surv_valid,
	input  wire logic  surv_stall,
	output surv_t      surv
);

	state_t               state_q;
	state_t               state_nxt;
	value_t               value_q;
	logic                 last_q;
	logic [CNT_BITS-1:0]  k_q;
	logic [CNT_BITS-1:0]  count_q;
	logic                 out_valid_q;
	surv_t                out_q;

	value_t               cand_value;
	logic                 cand_xfer;
	logic                 out_free;
	logic                 full;
	logic                 rem_start;
	logic                 rem_done;
	logic                 rem_zero;
	logic                 out_load;
	logic                 ram_we;
	value_t               ram_rdata;

	assign cand_value = VALUE_BITS'(cand.candidate_value);
	assign cand_xfer  = cand_valid && !cand_stall;
	assign out_free   = !out_valid_q || !surv_stall;
	assign full       = (count_q == CNT_BITS'(FILTER_CELLS));

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cand_valid) begin
					state_nxt = (cand_value > value_t'(1)) ? ST_READ : ST_END;
				end
			end
			ST_READ: state_nxt = (k_q == count_q) ? ST_PASS : ST_LOAD;
			ST_LOAD: state_nxt = ST_DIV;
			ST_DIV: begin
				if (rem_done) begin
					state_nxt = rem_zero ? ST_END : ST_READ;
				end
			end
			ST_PASS: begin
				if (out_free) begin
					state_nxt = ST_END;
				end
			end
			ST_END:  state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		cand_stall = 1'b1;
		rem_start  = 1'b0;
		out_load   = 1'b0;
		ram_we     = 1'b0;
		unique case (state_q) inside
			ST_IDLE: cand_stall = 1'b0;
			ST_LOAD: rem_start  = 1'b1;
			ST_PASS: begin
				out_load = out_free;
				ram_we   = out_free && !full;
			end
			ST_READ, ST_DIV, ST_END: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cand_xfer) begin
				k_q <= '0;
			end else if (state_q == ST_DIV && rem_done && !rem_zero) begin
				k_q <= k_q + 1'b1;
			end
			if (ram_we) begin
				count_q <= count_q + 1'b1;
			end else if (state_q == ST_END && last_q) begin
				count_q <= '0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!surv_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cand_xfer) begin
			value_q <= cand_value;
			last_q  <= cand.end_of_run;
		end
		if (out_load) begin
			out_q.survivor_value <= FIELD_BITS'(value_q);
			out_q.store_full     <= full;
		end
	end

	tdpf_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (FILTER_CELLS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[IDX_BITS-1:0]),
		.wdata (value_q),
		.raddr (k_q[IDX_BITS-1:0]),
		.rdata (ram_rdata)
	);

	tdpf_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (value_q),
		.divisor  (ram_rdata),
		.done     (rem_done),
		.zero     (rem_zero)
	);

	assign surv_valid = out_valid_q;
	assign surv       = out_q;

endmodule
`default_nettype wire

### tb/tb_trial_division_prime_filter_chain.sv
module tb_trial_division_prime_filter_chain;
	import tdpf_pkg::*;

	localparam int CLK_PERIOD   = 12;
	localparam int RESET_CYCLES = 5;
	// Long enough for one candidate tried against a full divisor store.
	localparam int SETTLE_CYCLES = 700;
	// Quiet-cycle limit: the slowest candidate plus long sender gaps and
	// receiver stalls, taken several times over.
	localparam int QUIET_LIMIT = 5000;
	// Random items per idling phase.
	localparam int PHASE_ITEMS = 195;

	typedef enum int {
		SEQ_FROM_TWO,   // ascending from 2: survivors are the primes
		SEQ_WIDE,       // mixed full-range and small values
		SEQ_HIGH_RUN,   // ascending run of large values, nearly all survive
		SEQ_NOISE       // below-two values, repeats, stray end-of-run marks
	} seq_kind_t;

	logic  clk;
	logic  arst_n;
	logic  cand_valid;
	logic  cand_stall;
	cand_t cand;
	logic  surv_valid;
	logic  surv_stall;
	surv_t surv;

	trial_division_prime_filter_chain uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cand_valid (cand_valid),
		.cand_stall (cand_stall),
		.cand       (cand),
		.surv_valid (surv_valid),
		.surv_stall (surv_stall),
		.surv       (surv)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Predicted divisor store, survivors still owed by the block, and the
	// idling knobs for both sides (percent of cycles).
	value_t      filter_divisors [FILTER_CELLS];
	int unsigned filter_count;
	surv_t       pending_survivors [$];
	int          idle_pct;
	int          stall_pct;

	int n_sent;
	int n_survivors;
	int n_full;
	int n_dropped;
	int n_clears;
	int n_errors;
	int quiet_cycles = 0;

	// Sieve prediction for one accepted candidate: drop below two or on the
	// first stored divisor that divides it, else owe a survivor and append
	// it when there is room. End-of-run empties the store afterwards.
	function automatic void sieve_predict(input cand_t c);
		value_t v;
		surv_t  r;
		bit     passes;
		v = c.candidate_value[VALUE_BITS-1:0];
		passes = (v >= 2);
		for (int k = 0; k < filter_count && passes; k++) begin
			if (v % filter_divisors[k] == 0)
				passes = 1'b0;
		end
		if (passes) begin
			r.survivor_value = FIELD_BITS'(v);
			r.store_full     = (filter_count >= FILTER_CELLS);
			if (!r.store_full) begin
				filter_divisors[filter_count] = v;
				filter_count++;
			end else begin
				n_full++;
			end
			n_survivors++;
			pending_survivors.push_back(r);
		end else begin
			n_dropped++;
		end
		if (c.end_of_run) begin
			filter_count = 0;
			n_clears++;
		end
	endfunction

	// One candidate transfer. Called at a rising edge; returns at the edge
	// of the transfer, so a following call can keep valid high without a
	// gap. Random idle cycles go in front of the item.
	task automatic send_candidate(input logic [FIELD_BITS-1:0] value, input logic last);
		cand_t c;
		c.candidate_value = value;
		c.end_of_run      = last;
		while ($urandom_range(0, 99) < idle_pct) begin
			cand_valid <= 1'b0;
			@(posedge clk);
		end
		cand_valid <= 1'b1;
		cand       <= c;
		do @(posedge clk); while (cand_stall !== 1'b0);
		sieve_predict(c);
		n_sent++;
	endtask

	// Sender goes quiet until every owed survivor has been taken. The queue
	// is checked only after a rising edge, so valid is never lowered and raised in one step.
	task automatic wait_for_survivors();
		cand_valid <= 1'b0;
		do @(posedge clk); while (pending_survivors.size() != 0);
	endtask

	task automatic run_sequence(input seq_kind_t kind, input int len);
		logic [FIELD_BITS-1:0] value;
		logic [FIELD_BITS-1:0] prev;
		logic                  last;
		int                    start;
		start = (kind == SEQ_HIGH_RUN) ? $urandom_range(1000, 65535 - len) : 2;
		prev  = '0;
		for (int i = 0; i < len; i++) begin
			case (kind) inside
				SEQ_FROM_TWO, SEQ_HIGH_RUN: value = FIELD_BITS'(start + i);
				SEQ_WIDE: begin
					if ($urandom_range(0, 1))
						value = FIELD_BITS'($urandom);
					else
						value = FIELD_BITS'($urandom_range(2, 400));
				end
				default: begin
					case ($urandom_range(0, 3))
						0: value = FIELD_BITS'($urandom_range(0, 1));
						1: value = prev;
						2: value = FIELD_BITS'($urandom);
						default: value = '1;
					endcase
				end
			endcase
			// well-formed runs close with end-of-run; noise drops it anywhere
			if (kind == SEQ_NOISE)
				last = ($urandom_range(0, 99) < 15);
			else
				last = (i == len - 1);
			send_candidate(value, last);
			prev = value;
		end
	endtask

	// Zero and one are dropped, also when carrying end-of-run.
	task automatic test_below_two();
		send_candidate(16'd0, 1'b0);
		send_candidate(16'd1, 1'b0);
		send_candidate(16'd0, 1'b1);
		send_candidate(16'd1, 1'b1);
	endtask

	// Field extremes: all-ones and top-bit-only survive an empty store,
	// 0xFFFE dies on 2, the largest 16-bit prime survives.
	task automatic test_extremes();
		send_candidate(16'hFFFF, 1'b0);
		send_candidate(16'h8000, 1'b0);
		send_candidate(16'd2, 1'b0);
		send_candidate(16'hFFFE, 1'b0);
		send_candidate(16'd65521, 1'b1);
	endtask

	// Equal to a stored divisor, or a multiple of one: dropped.
	task automatic test_repeated_values();
		send_candidate(16'd7, 1'b0);
		send_candidate(16'd7, 1'b0);
		send_candidate(16'd49, 1'b0);
		send_candidate(16'd3, 1'b0);
		send_candidate(16'd21, 1'b0);
		send_candidate(16'd11, 1'b1);
	endtask

	// Clear lands after its own item, for an emitted and a dropped one.
	task automatic test_end_of_run();
		send_candidate(16'd5, 1'b1);
		send_candidate(16'd5, 1'b0);
		send_candidate(16'd10, 1'b1);
		send_candidate(16'd10, 1'b0);
		send_candidate(16'd20, 1'b1);
	endtask

	// 2..150 gives 35 primes: the last three come out with store_full set.
	task automatic test_full_store();
		run_sequence(SEQ_FROM_TWO, 149);
	endtask

	// Four idling phases, each closed by a full drain of owed survivors.
	task automatic test_random_traffic();
		int        first;
		int        r;
		int        len;
		seq_kind_t kind;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 52; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 52; end
				default: begin idle_pct = 15; stall_pct = 15; end
			endcase
			first = n_sent;
			while (n_sent - first < PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				if (r < 40) begin
					kind = SEQ_FROM_TWO;
					len  = $urandom_range(20, 160);
				end else if (r < 65) begin
					kind = SEQ_WIDE;
					len  = $urandom_range(5, 45);
				end else if (r < 85) begin
					kind = SEQ_HIGH_RUN;
					len  = $urandom_range(8, 40);
				end else begin
					kind = SEQ_NOISE;
					len  = $urandom_range(4, 20);
				end
				// keep each phase at its item budget
				if (len > PHASE_ITEMS - (n_sent - first))
					len = PHASE_ITEMS - (n_sent - first);
				run_sequence(kind, len);
			end
			wait_for_survivors();
		end
	endtask

	// Survivor checking, receiver stall and the quiet-cycle watchdog. All
	// handshake signals are read as they stood before the edge.
	always @(posedge clk) begin : survivor_check
		surv_t want;
		if (arst_n === 1'b1 && surv_valid === 1'b1 && surv_stall === 1'b0) begin
			if (pending_survivors.size() == 0) begin
				$error("unexpected survivor: survivor_value=%0d store_full=%0b",
					surv.survivor_value, surv.store_full);
				n_errors++;
			end else begin
				want = pending_survivors.pop_front();
				if (surv.survivor_value !== want.survivor_value) begin
					$error("survivor_value: expected %0d, got %0d",
						want.survivor_value, surv.survivor_value);
					n_errors++;
				end
				if (surv.store_full !== want.store_full) begin
					$error("store_full: expected %0b, got %0b",
						want.store_full, surv.store_full);
					n_errors++;
				end
			end
		end
		if ((cand_valid === 1'b1 && cand_stall === 1'b0) ||
				(surv_valid === 1'b1 && surv_stall === 1'b0))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d survivors owed",
				quiet_cycles, pending_survivors.size());
			$display("RESULT: ERROR");
			$finish;
		end
		surv_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	initial begin
		cand_valid   = 1'b0;
		cand         = '0;
		surv_stall   = 1'b0;
		arst_n       = 1'b0;
		idle_pct     = 0;
		stall_pct    = 0;
		filter_count = 0;
		n_sent       = 0;
		n_survivors  = 0;
		n_full       = 0;
		n_dropped    = 0;
		n_clears     = 0;
		n_errors     = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed cases back to back, no idling
		test_below_two();
		test_extremes();
		test_repeated_values();
		test_end_of_run();
		test_full_store();
		// sender holds off here until the block has caught up
		wait_for_survivors();
		test_random_traffic();

		// all owed survivors are in; give a late extra one time to show up
		wait_for_survivors();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d candidates: %0d survivors (%0d with store full), %0d dropped.",
			n_sent, n_survivors, n_full, n_dropped);
		$display("Store cleared %0d times; idling phases none, sender, receiver, both.",
			n_clears);
		if (n_errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
